// File: rtl/core/prr_pkg.sv
package prr_pkg;

  localparam logic [20:0] SCALE_Q16  = 21'd1223657;
  localparam logic [16:0] POWER_MAX  = 17'd65535;
  localparam logic [15:0] TARGET_RST = 16'd730;
  localparam logic [7:0]  RATE_HIGH  = 8'd150;
  localparam logic [7:0]  RATE_LOW   = 8'd50;
  localparam logic [7:0]  RATE_MID   = 8'd100;
  localparam logic [7:0]  BAND_STEP  = 8'd5;
  localparam int          BAND_WIDTH = 20;
  localparam int          BAND_TOP   = 10;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_UPD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [3:0] band_of(input logic [15:0] d);
    logic [3:0] b;
    b = 4'd0;
    for (int k = 1; k <= BAND_TOP; k++) begin
      if (d > 16'(k * BAND_WIDTH)) begin
        b = b + 4'd1;
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/core/prr_ring.sv
module prr_ring #(
  parameter int DEPTH  = 30,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/prr_div.sv
module prr_div #(
  parameter int N_W = 21,
  parameter int D_W = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int STEP_W = $clog2(N_W + 1);

  logic [D_W-1:0]    rem;
  logic [N_W-1:0]    quo;
  logic [D_W-1:0]    dvs;
  logic [STEP_W-1:0] cnt;
  logic [D_W:0]      shifted;
  logic [D_W:0]      diff;
  logic              ge;

  assign shifted  = {rem, quo[N_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/power_estimate_rate_regulator.sv
// Scales each 12-bit converter code to power (Q16 factor, saturating at 65535), feeds it
// into a WINDOW-deep ring moving average held in a synchronous memory with a running sum,
// and compares the average with target_power to give a two-level rate_code and a banded
// advisory_rate. One transaction at a time is processed: an item passes through S_READ,
// S_UPD, S_DIV and S_DONE, its stay in S_DIV set by the restoring divider that produces
// one quotient bit per cycle, and the next transaction is accepted only once the previous
// one has left S_DONE, which waits while an earlier result is still held and not taken.
// The memory needs no clearing pass after reset, since the value read from it is replaced
// by zero until the window fills.
// A finished result waits in the output register while the next transaction is accepted.
module power_estimate_rate_regulator #(
  parameter int WINDOW = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] adc_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] power_estimate,
  output logic [7:0]  rate_code,
  output logic [7:0]  advisory_rate
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = 16 + $clog2(WINDOW);

  prr_pkg::state_t   state;
  prr_pkg::state_t   state_next;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [15:0]      target_power;
  logic [11:0]      code;
  logic [16:0]      prod_hi;
  logic [32:0]      prod;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic             window_full;
  logic             window_full_next;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic [CNT_W-1:0] divisor;
  logic [15:0]      power;
  logic [15:0]      old_sample;
  logic [15:0]      rd_data;
  logic [SUM_W-1:0] quotient;
  logic [15:0]      avg;
  logic             under;
  logic [15:0]      diff;
  logic [3:0]       band;
  logic [7:0]       band_rate;
  logic             out_free;

  prr_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (state == prr_pkg::S_UPD),
    .waddr (wr_ptr),
    .wdata (power),
    .raddr (wr_ptr),
    .rdata (rd_data)
  );

  prr_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum_next),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_ready  = (state == prr_pkg::S_IDLE);
  assign div_start = (state == prr_pkg::S_UPD);
  assign out_free  = !out_valid || out_ready;

  assign prod       = {21'd0, code} * {12'd0, prr_pkg::SCALE_Q16};
  assign power      = (prod_hi > prr_pkg::POWER_MAX) ? 16'hFFFF : prod_hi[15:0];
  assign old_sample = window_full ? rd_data : 16'd0;

  always_comb begin
    running_sum_next = running_sum + SUM_W'(power) - SUM_W'(old_sample);
    if (wr_ptr == PTR_W'(WINDOW - 1)) begin
      wr_ptr_next      = '0;
      window_full_next = 1'b1;
    end else begin
      wr_ptr_next      = wr_ptr + PTR_W'(1);
      window_full_next = window_full;
    end
    divisor = window_full_next ? CNT_W'(WINDOW) : CNT_W'(wr_ptr_next);
  end

  assign under     = target_power > avg;
  assign diff      = under ? (target_power - avg) : (avg - target_power);
  assign band      = prr_pkg::band_of(diff);
  assign band_rate = prr_pkg::BAND_STEP * {4'd0, band};

  always_comb begin
    state_next = state;
    case (state)
      prr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = prr_pkg::S_READ;
        end
      end
      prr_pkg::S_READ: state_next = prr_pkg::S_UPD;
      prr_pkg::S_UPD:  state_next = prr_pkg::S_DIV;
      prr_pkg::S_DIV: begin
        if (div_done) begin
          state_next = prr_pkg::S_DONE;
        end
      end
      prr_pkg::S_DONE: begin
        if (out_free) begin
          state_next = prr_pkg::S_IDLE;
        end
      end
      default: state_next = prr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prr_pkg::S_IDLE;
      target_power <= prr_pkg::TARGET_RST;
      wr_ptr       <= '0;
      window_full  <= 1'b0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        target_power <= cfg_data;
      end
      if (state == prr_pkg::S_UPD) begin
        wr_ptr      <= wr_ptr_next;
        window_full <= window_full_next;
        running_sum <= running_sum_next;
      end
      if (state == prr_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code <= adc_code;
    end
    if (state == prr_pkg::S_READ) begin
      prod_hi <= prod[32:16];
    end
    if (state == prr_pkg::S_DIV && div_done) begin
      avg <= quotient[15:0];
    end
    if (state == prr_pkg::S_DONE && out_free) begin
      power_estimate <= avg;
      rate_code      <= under ? prr_pkg::RATE_HIGH : prr_pkg::RATE_LOW;
      advisory_rate  <= under ? (prr_pkg::RATE_MID + band_rate)
                              : (prr_pkg::RATE_MID - band_rate);
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= PTR_W'(WINDOW - 1))
    else $error("Write pointer left the window.");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> divisor != '0)
    else $error("Divider started with a zero divisor.");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !in_ready)
    else $error("Input ready while the divider is busy.");

  a_rate_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rate_code == prr_pkg::RATE_HIGH) |-> advisory_rate >= prr_pkg::RATE_MID)
    else $error("Advisory rate below midpoint while under target.");

endmodule

// File: tb/sv/power_estimate_rate_regulator_test.sv
module power_estimate_rate_regulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = 30;
  localparam logic [20:0] POWER_SCALE = 21'd1223657;
  localparam int unsigned BAND_SPAN = 20;
  localparam int unsigned BAND_LIMIT = 10;
  localparam int unsigned RATE_UNDER = 150;
  localparam int unsigned RATE_OVER = 50;
  localparam int unsigned RATE_CENTER = 100;
  localparam int unsigned RATE_STEP = 5;
  localparam logic [15:0] TARGET_AT_RESET = 16'd730;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [15:0] power;
    logic [7:0] rate;
    logic [7:0] advice;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] adc_code = 12'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] power_estimate;
  logic [7:0] rate_code;
  logic [7:0] advisory_rate;

  logic [11:0] pending_codes[$];
  reading_t expected_readings[$];
  logic in_taken = 1'b0;
  bit calm = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [15:0] power_ring[WINDOW];
  int unsigned ring_ptr;
  bit ring_full;
  int unsigned ring_sum;
  logic [15:0] target_setting;

  power_estimate_rate_regulator #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .adc_code(adc_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .power_estimate(power_estimate),
    .rate_code(rate_code),
    .advisory_rate(advisory_rate)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] scaled_power(input logic [11:0] code);
    logic [32:0] product;
    product = (33'(code) * 33'(POWER_SCALE)) >> 16;
    return (product > 33'd65535) ? 16'hFFFF : product[15:0];
  endfunction

  function automatic int unsigned band_index(input int unsigned gap);
    if (gap <= BAND_SPAN) begin
      return 0;
    end
    return ((gap - 1) / BAND_SPAN > BAND_LIMIT) ? BAND_LIMIT : (gap - 1) / BAND_SPAN;
  endfunction

  function automatic reading_t average_power(input logic [11:0] code);
    reading_t r;
    logic [15:0] sample;
    int unsigned divisor;
    int unsigned mean;
    sample = scaled_power(code);
    ring_sum = ring_sum + sample - power_ring[ring_ptr];
    power_ring[ring_ptr] = sample;
    ring_ptr = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;
    if (ring_ptr == 0) begin
      ring_full = 1'b1;
    end
    divisor = ring_full ? WINDOW : ring_ptr;
    mean = ring_sum / divisor;
    r.power = mean[15:0];
    if (target_setting > r.power) begin
      r.rate = 8'(RATE_UNDER);
      r.advice = 8'(RATE_CENTER + RATE_STEP * band_index(target_setting - r.power));
    end else begin
      r.rate = 8'(RATE_OVER);
      r.advice = 8'(RATE_CENTER - RATE_STEP * band_index(r.power - target_setting));
    end
    return r;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 20);
  endfunction

  task automatic report_mismatch(input string message);
    $display("%0t: mismatch: %s", $realtime, message);
    mismatches++;
  endtask

  task automatic write_target(input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    target_setting = value;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_codes.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_codes.size() != 0 && !take_break()) begin
        in_valid <= 1'b1;
        adc_code <= pending_codes.pop_front();
      end else begin
        in_valid <= 1'b0;
        adc_code <= 12'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && !take_break();
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_readings.push_back(average_power(adc_code));
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, power %0d",
                                    power_estimate));
        end else begin
          want = expected_readings.pop_front();
          if (power_estimate !== want.power) begin
            report_mismatch($sformatf("power_estimate %0d, expected %0d",
                                      power_estimate, want.power));
          end
          if (rate_code !== want.rate) begin
            report_mismatch($sformatf("rate_code %0d, expected %0d", rate_code, want.rate));
          end
          if (advisory_rate !== want.advice) begin
            report_mismatch($sformatf("advisory_rate %0d, expected %0d",
                                      advisory_rate, want.advice));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int base;
    int goal;
    int offset;
    logic [11:0] code;
    for (int i = 0; i < WINDOW; i++) begin
      power_ring[i] = 16'd0;
    end
    ring_ptr = 0;
    ring_full = 1'b0;
    ring_sum = 0;
    target_setting = TARGET_AT_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // The first transactions run through warm-up with the target left at its reset value.
    pending_codes = '{12'd0, 12'd4095, 12'd1, 12'd3509, 12'd3510, 12'hAAA, 12'h555,
                      12'h800, 12'h7FF, 12'd39, 12'd40, 12'd41};
    wait_idle();
    write_target(16'd0);
    pending_codes = '{12'd0, 12'd4095, 12'd0};
    wait_idle();
    write_target(16'hFFFF);
    pending_codes = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                      12'd3510};
    wait_idle();

    // Most phases hold the input near one level so the average settles close to the
    // target and walks through the advisory bands; every fourth phase is full-range noise.
    for (int phase = 0; phase < 16; phase++) begin
      calm = (phase == 5) || (phase == 6);
      base = $urandom_range(4095);
      if (phase % 4 == 0) begin
        goal = $urandom_range(65535);
      end else begin
        goal = int'(scaled_power(12'(base))) + int'($urandom_range(460)) - 230;
      end
      if (phase == 2) begin
        goal = 0;
      end else if (phase == 9) begin
        goal = 65535;
      end
      goal = (goal < 0) ? 0 : (goal > 65535) ? 65535 : goal;
      write_target(16'(goal));
      for (int k = 0; k < 100; k++) begin
        if (phase % 4 == 0 || $urandom_range(9) == 0) begin
          code = 12'($urandom);
        end else begin
          offset = base + int'($urandom_range(6)) - 3;
          code = (offset < 0) ? 12'd0 : (offset > 4095) ? 12'd4095 : 12'(offset);
        end
        pending_codes.push_back(code);
      end
      wait_idle();
    end
    calm = 1'b0;

    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
